### rtl/core/segment_capacity_reservation_core_defines.svh
// Assertion macros used by the core, which checks its own logic.
`ifndef SEGMENT_CAPACITY_RESERVATION_CORE_DEFINES_SVH
`define SEGMENT_CAPACITY_RESERVATION_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/scr_pkg.sv
package scr_pkg;

   localparam int DEF_MAX_STATIONS = 2048;
   localparam int DEF_AMOUNT_BITS  = 16;

   localparam int STATION_W = 12;
   localparam int AMOUNT_W  = 16;
   localparam int CAP_W     = 16;
   localparam int TOTAL_W   = 32;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic CSR_IDX_CAPACITY = 1'b0;
   localparam logic CSR_IDX_STATIONS = 1'b1;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_IDLE,
      ST_CHECK,
      ST_MIN,
      ST_GRANT,
      ST_SUB,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                 begin_job;
      logic [STATION_W-1:0] start_station;
      logic [STATION_W-1:0] end_station;
      logic [AMOUNT_W-1:0]  amount;
      logic                 final_request;
   } req_type;

   typedef struct packed {
      logic [AMOUNT_W-1:0] granted;
      logic [TOTAL_W-1:0]  total_carried;
      logic                invalid;
      logic                job_done;
   } rsp_type;

   typedef struct packed {
      logic [CAP_W-1:0]     capacity;
      logic [STATION_W-1:0] stations_in_use;
   } cfg_type;

endpackage

### rtl/core/scr_csr.sv
module scr_csr
   import scr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [CAP_W-1:0]     capacity_ff, capacity_in;
   logic [STATION_W-1:0] stations_ff, stations_in;
   logic                 reg_idx;
   logic                 wr_en;

   assign reg_idx = paddr[2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      capacity_in = capacity_ff;
      stations_in = stations_ff;
      if (wr_en) begin
         case (reg_idx)
            CSR_IDX_CAPACITY: capacity_in = pwdata[CAP_W-1:0];
            CSR_IDX_STATIONS: stations_in = pwdata[STATION_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= '0;
         stations_ff <= STATION_W'(2048);
      end else begin
         capacity_ff <= capacity_in;
         stations_ff <= stations_in;
      end
   end

   always_comb begin
      case (reg_idx)
         CSR_IDX_CAPACITY: prdata = CSR_DATA_W'(capacity_ff);
         CSR_IDX_STATIONS: prdata = CSR_DATA_W'(stations_ff);
         default:          prdata = '0;
      endcase
   end

   assign cfg.capacity        = capacity_ff;
   assign cfg.stations_in_use = stations_ff;

endmodule

### rtl/core/scr_alu.sv
module scr_alu
   import scr_pkg::*;
#(
   parameter int WIDTH = DEF_AMOUNT_BITS
) (
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   output logic [WIDTH-1:0] diff,
   output logic             borrow
);

   logic [WIDTH:0] full;

   assign full   = {1'b0, a} - {1'b0, b};
   assign diff   = full[WIDTH-1:0];
   assign borrow = full[WIDTH];

endmodule

### rtl/core/scr_store.sv
module scr_store
   import scr_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_STATIONS,
   parameter int WIDTH = DEF_AMOUNT_BITS,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/segment_capacity_reservation_core.sv
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  req_payload (req_type)
// rsp      out        rsp_valid / rsp_ready  rsp_payload (rsp_type)
// csr      in         psel, penable, pwrite  paddr, pwdata, prdata; pready tied high
//
// A request runs a range check, a min pass over its segments, then a read-modify-write
// pass; an invalid request skips both passes and one that grants nothing skips the second.
// Both passes move one store word per cycle through a single shared subtractor.
// A begin_job request first refills every entry with the configured capacity.
// After reset the store is cleared while req_ready stays low.
// A result waits in its output register, so a stalled rsp blocks only the next result.
`include "segment_capacity_reservation_core_defines.svh"

module segment_capacity_reservation_core
   import scr_pkg::*;
#(
   parameter int MAX_STATIONS = DEF_MAX_STATIONS,
   parameter int AMOUNT_BITS  = DEF_AMOUNT_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int ADDR_W = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
   localparam int AW     = AMOUNT_BITS;

   cfg_type cfg;

   state_type            state_ff, state_in;
   logic [STATION_W-1:0] start_ff, start_in;
   logic [STATION_W-1:0] end_ff, end_in;
   logic [AW-1:0]        amt_ff, amt_in;
   logic                 fin_ff, fin_in;
   logic                 bad_ff, bad_in;
   logic [STATION_W-1:0] ptr_ff, ptr_in;
   logic [STATION_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic [ADDR_W-1:0]    fill_cnt_ff, fill_cnt_in;
   logic [AW-1:0]        fill_val_ff, fill_val_in;
   logic                 fill_run_ff, fill_run_in;
   logic [AW-1:0]        min_ff, min_in;
   logic [AW-1:0]        grant_ff, grant_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [AW-1:0]        mem_wdata;
   logic [AW-1:0]        mem_rdata;
   logic [AW-1:0]        alu_a, alu_b, alu_diff;
   logic                 alu_borrow;
   logic                 issue;
   logic [31:0]          limit;
   logic [TOTAL_W:0]     total_sum;

   scr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   scr_store #(
      .DEPTH (MAX_STATIONS),
      .WIDTH (AW)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (ADDR_W'(ptr_ff)),
      .rdata (mem_rdata)
   );

   scr_alu #(
      .WIDTH (AW)
   ) u_alu (
      .a      (alu_a),
      .b      (alu_b),
      .diff   (alu_diff),
      .borrow (alu_borrow)
   );

   assign limit = (32'(cfg.stations_in_use) > 32'(MAX_STATIONS)) ?
                  32'(MAX_STATIONS) : 32'(cfg.stations_in_use);
   assign issue = ptr_ff < end_ff;
   assign total_sum = {1'b0, total_ff} + (TOTAL_W + 1)'(grant_in);

   always_comb begin
      state_in     = state_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      amt_in       = amt_ff;
      fin_in       = fin_ff;
      bad_in       = bad_ff;
      ptr_in       = ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_pend_in   = 1'b0;
      fill_cnt_in  = fill_cnt_ff;
      fill_val_in  = fill_val_ff;
      fill_run_in  = fill_run_ff;
      min_in       = min_ff;
      grant_in     = grant_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = ADDR_W'(wr_ptr_ff);
      mem_wdata    = alu_diff;
      alu_a        = mem_rdata;
      alu_b        = min_ff;

      case (state_ff)
         ST_FILL: begin
            mem_we      = 1'b1;
            mem_waddr   = fill_cnt_ff;
            mem_wdata   = fill_val_ff;
            fill_cnt_in = fill_cnt_ff + 1'b1;
            if (fill_cnt_ff == ADDR_W'(MAX_STATIONS - 1)) begin
               fill_cnt_in = '0;
               state_in    = fill_run_ff ? ST_CHECK : ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               start_in = req_payload.start_station;
               end_in   = req_payload.end_station;
               amt_in   = AW'(req_payload.amount);
               fin_in   = req_payload.final_request;
               if (req_payload.begin_job) begin
                  fill_val_in = AW'(cfg.capacity);
                  fill_cnt_in = '0;
                  fill_run_in = 1'b1;
                  total_in    = '0;
                  state_in    = ST_FILL;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            bad_in   = (start_ff >= end_ff) || (32'(end_ff) > limit);
            ptr_in   = start_ff;
            min_in   = '1;
            grant_in = '0;
            state_in = bad_in ? ST_DONE : ST_MIN;
         end
         ST_MIN: begin
            alu_a = mem_rdata;
            alu_b = min_ff;
            if (issue) begin
               ptr_in     = ptr_ff + 1'b1;
               rd_pend_in = 1'b1;
            end
            if (rd_pend_ff && alu_borrow) begin
               min_in = mem_rdata;
            end
            if (!issue && !rd_pend_ff) begin
               state_in = ST_GRANT;
            end
         end
         ST_GRANT: begin
            alu_a    = amt_ff;
            alu_b    = min_ff;
            grant_in = alu_borrow ? amt_ff : min_ff;
            ptr_in   = start_ff;
            if (grant_in == '0) begin
               state_in = ST_DONE;
            end else begin
               total_in = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
               state_in = ST_SUB;
            end
         end
         ST_SUB: begin
            alu_a     = mem_rdata;
            alu_b     = grant_ff;
            mem_we    = rd_pend_ff;
            wr_ptr_in = ptr_ff;
            if (issue) begin
               ptr_in     = ptr_ff + 1'b1;
               rd_pend_in = 1'b1;
            end
            if (!issue && !rd_pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.granted       = AMOUNT_W'(grant_ff);
               rsp_in.total_carried = total_ff;
               rsp_in.invalid       = bad_ff;
               rsp_in.job_done      = fin_ff;
               state_in             = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         fill_cnt_ff  <= '0;
         fill_val_ff  <= '0;
         fill_run_ff  <= 1'b0;
         rd_pend_ff   <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_cnt_ff  <= fill_cnt_in;
         fill_val_ff  <= fill_val_in;
         fill_run_ff  <= fill_run_in;
         rd_pend_ff   <= rd_pend_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff  <= start_in;
      end_ff    <= end_in;
      amt_ff    <= amt_in;
      fin_ff    <= fin_in;
      bad_ff    <= bad_in;
      ptr_ff    <= ptr_in;
      wr_ptr_ff <= wr_ptr_in;
      min_ff    <= min_in;
      grant_ff  <= grant_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `SCR_ASSERT_SAME(a_invalid_no_grant, clock, reset,
      rsp_valid && rsp_payload.invalid, rsp_payload.granted == '0,
      "An invalid request returned a nonzero grant.")

   `SCR_ASSERT_SAME(a_grant_bounded, clock, reset,
      state_ff == ST_DONE, (grant_ff <= amt_ff) && (grant_ff <= min_ff),
      "The grant exceeds the requested amount or the range minimum.")

   `SCR_ASSERT_NEXT(a_transfer_starts_work, clock, reset,
      req_valid && req_ready, state_ff == ST_FILL || state_ff == ST_CHECK,
      "A request transfer did not start a refill or a range check.")

endmodule

### bench/segment_capacity_reservation_core_tb.sv
`timescale 1ns / 1ps

module segment_capacity_reservation_core_tb
   import scr_pkg::*;
();

   localparam int CYCLE_LIMIT = 5_000_000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_payload;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int unsigned cycle_count = 0;
   int          rsp_hold_cycles = 0;
   bit          steady_flow = 1'b0;

   segment_capacity_reservation_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   class capacity_ledger;
      logic [CAP_W-1:0]     seg_left [DEF_MAX_STATIONS];
      logic [CAP_W-1:0]     capacity_reg;
      logic [STATION_W-1:0] stations_reg;
      logic [TOTAL_W-1:0]   job_total;
      rsp_type              awaited [$];
      int unsigned          errors;
      int unsigned          booked;
      int unsigned          checked;
      int unsigned          invalid_seen;
      int unsigned          jobs_begun;

      function new();
         capacity_reg = '0;
         stations_reg = STATION_W'(DEF_MAX_STATIONS);
         job_total = '0;
         foreach (seg_left[p]) seg_left[p] = '0;
         errors = 0;
         booked = 0;
         checked = 0;
         invalid_seen = 0;
         jobs_begun = 0;
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction

      function void set_register(logic idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_IDX_CAPACITY) begin
            capacity_reg = value[CAP_W-1:0];
         end else begin
            stations_reg = value[STATION_W-1:0];
         end
      endfunction

      function void book_request(req_type r);
         rsp_type             want;
         int unsigned         reach;
         logic [CAP_W-1:0]    tightest;
         logic [TOTAL_W:0]    sum;
         reach = (stations_reg > DEF_MAX_STATIONS) ? DEF_MAX_STATIONS : stations_reg;
         if (r.begin_job) begin
            foreach (seg_left[p]) seg_left[p] = capacity_reg;
            job_total = '0;
            jobs_begun++;
         end
         want.granted = '0;
         want.invalid = (r.start_station >= r.end_station) || (r.end_station > reach);
         if (!want.invalid) begin
            tightest = seg_left[r.start_station];
            for (int p = r.start_station + 1; p < r.end_station; p++) begin
               if (seg_left[p] < tightest) tightest = seg_left[p];
            end
            want.granted = (r.amount < tightest) ? r.amount : tightest;
            for (int p = r.start_station; p < r.end_station; p++) begin
               seg_left[p] = seg_left[p] - want.granted;
            end
            sum = {1'b0, job_total} + want.granted;
            job_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
         end else begin
            invalid_seen++;
         end
         want.total_carried = job_total;
         want.job_done = r.final_request;
         awaited.insert(awaited.size(), want);
         booked++;
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         checked++;
         if (awaited.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with no request pending", checked));
         end else begin
            want = awaited.pop_front();
            if (got.granted !== want.granted)
               report_mismatch($sformatf("result %0d granted %0d, expected %0d",
                                         checked, got.granted, want.granted));
            if (got.total_carried !== want.total_carried)
               report_mismatch($sformatf("result %0d total_carried %0d, expected %0d",
                                         checked, got.total_carried, want.total_carried));
            if (got.invalid !== want.invalid)
               report_mismatch($sformatf("result %0d invalid %b, expected %b",
                                         checked, got.invalid, want.invalid));
            if (got.job_done !== want.job_done)
               report_mismatch($sformatf("result %0d job_done %b, expected %b",
                                         checked, got.job_done, want.job_done));
         end
      endtask
   endclass

   capacity_ledger ledger = new();

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic int draw_gap();
      return steady_flow ? 0 : $urandom_range(0, 15);
   endfunction

   function automatic logic [AMOUNT_W-1:0] pick_amount();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2, 3: return AMOUNT_W'($urandom_range(1, 16));
         default: return AMOUNT_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic req_type make_request(int job_start, int s, int e, int amt, int last);
      req_type r;
      r.begin_job = 1'(job_start);
      r.start_station = STATION_W'(s);
      r.end_station = STATION_W'(e);
      r.amount = AMOUNT_W'(amt);
      r.final_request = 1'(last);
      return r;
   endfunction

   function automatic req_type noise_request();
      return make_request(int'($urandom_range(0, 3) == 0), int'($urandom_range(0, 4095)),
                          int'($urandom_range(0, 4095)), int'($urandom_range(0, 65535)),
                          int'($urandom_range(0, 1)));
   endfunction

   // Valid stays high across back-to-back transfers; it drops when a gap is drawn
   // or when the sender waits for the results to drain.
   task automatic send_request(req_type r);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ledger.book_request(r);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ledger.outstanding() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [CSR_DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      ledger.set_register(idx, value);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== value)
         ledger.report_mismatch($sformatf("register %0d reads %0h, expected %0h",
                                          idx, prdata, value));
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Ends never fall, and a start drawn below the previous start keeps the same end.
   task automatic run_job(int count, int reach, int span_cap);
      req_type r;
      int      e;
      int      s;
      int      s_prev;
      int      hi;
      e = $urandom_range(1, reach);
      s_prev = 0;
      for (int k = 0; k < count; k++) begin
         hi = (span_cap < e) ? span_cap : e;
         if (k > 0 && $urandom_range(0, 3) == 0 && s_prev > e - hi) begin
            s = $urandom_range(e - hi, s_prev - 1);
         end else begin
            if (k > 0) e = (e + 3 > reach) ? reach : e + $urandom_range(1, 3);
            hi = (span_cap < e) ? span_cap : e;
            s = e - $urandom_range(1, hi);
         end
         if ($urandom_range(0, 7) == 0) begin
            r = noise_request();
         end else begin
            r = make_request(int'(k == 0), s, e, int'(pick_amount()), int'(k == count - 1));
         end
         send_request(r);
         s_prev = s;
      end
   endtask

   initial begin : result_sink
      int stall;
      @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            if ($urandom_range(0, 1) == 1) begin
               @(posedge clock);
               while (!rsp_valid) @(posedge clock);
            end
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         ledger.check_result(rsp_payload);
      end
   end

   initial begin : stimulus
      int cap;
      int reach;
      int span;
      int phase_base;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_request(make_request(0, 0, 1, 5, 0));
      drain_results();
      csr_write(CSR_IDX_CAPACITY, 32'd65535);
      csr_write(CSR_IDX_STATIONS, 32'd2048);
      send_request(make_request(1, 2047, 2048, 'hFFFF, 0));
      send_request(make_request(0, 0, 2048, 100, 0));
      send_request(make_request(0, 0, 2047, 0, 0));
      send_request(make_request(0, 0, 2047, 'hAAAA, 0));
      send_request(make_request(0, 5, 10, 'h5555, 0));
      send_request(make_request(0, 10, 5, 9, 0));
      send_request(make_request(0, 7, 7, 9, 0));
      send_request(make_request(0, 2048, 2048, 9, 0));
      send_request(make_request(0, 0, 2049, 9, 0));
      send_request(make_request(0, 4095, 4095, 'hFFFF, 1));
      send_request(make_request(0, 100, 4095, 1, 1));
      send_request(make_request(0, 2046, 2047, 3, 1));
      drain_results();
      csr_write(CSR_IDX_CAPACITY, 32'h1234);
      csr_write(CSR_IDX_STATIONS, 32'd16);
      send_request(make_request(0, 0, 5, 1, 0));
      send_request(make_request(0, 0, 17, 1, 0));
      send_request(make_request(0, 15, 16, 'hFFFF, 0));
      send_request(make_request(1, 0, 16, 'hFFFF, 1));
      send_request(make_request(0, 0, 1, 'hFFFF, 0));
      drain_results();
      csr_write(CSR_IDX_CAPACITY, 32'd0);
      csr_write(CSR_IDX_STATIONS, 32'd2);
      send_request(make_request(1, 0, 2, 7, 0));
      send_request(make_request(0, 1, 2, 7, 0));
      send_request(make_request(0, 0, 3, 7, 0));
      send_request(make_request(0, 1, 3, 7, 1));

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin cap = 65535; reach = 2048; span = 24; end
            1: begin cap = 200; reach = 40; span = 40; end
            2: begin cap = 0; reach = 2; span = 2; end
            3: begin cap = 1000; reach = 12; span = 12; end
            4: begin cap = 1; reach = 2048; span = 24; end
            5: begin
               cap = $urandom_range(0, 65535);
               reach = $urandom_range(3, 64);
               span = reach;
            end
            6: begin cap = 32768; reach = 2047; span = 2047; end
            default: begin
               cap = $urandom_range(0, 65535);
               reach = $urandom_range(2, 2048);
               span = 64;
            end
         endcase
         drain_results();
         csr_write(CSR_IDX_CAPACITY, cap);
         csr_write(CSR_IDX_STATIONS, reach);
         steady_flow = (ph == 1 || ph == 3 || ph == 5);
         if (ph == 3) rsp_hold_cycles = 400;
         phase_base = ledger.booked;
         while (ledger.booked - phase_base < 12) begin
            run_job($urandom_range(4, 10), reach, span);
         end
      end
      steady_flow = 1'b0;

      drain_results();
      repeat (20) @(posedge clock);
      $display("Run sent %0d requests in %0d jobs across 11 register settings.",
               ledger.booked, ledger.jobs_begun);
      $display("Checked %0d results, %0d of them flagged invalid, with %0d errors.",
               ledger.checked, ledger.invalid_seen, ledger.errors);
      if (ledger.errors == 0 && ledger.outstanding() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
